>>> src/tbft_pkg.sv
// Shared types and constants of the token bucket throttle.
package tbft_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W       = $clog2(MAX_RESULTS + 1);
    localparam int TAG_W       = 8;
    localparam int TOK_W       = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = CFG_IDX_W'(1);

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic             borrow;
        logic [TOK_W:0]   value;
    } t_alu_res;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_ADD,
        S_CAP,
        S_FETCH,
        S_CHECK
    } t_state;

endpackage

>>> src/tbft_alu.sv
// Shared add/subtract unit with borrow out, used for every refill, charge, cap and compare.
module tbft_alu (
    input  tbft_pkg::t_alu_op             i_op,
    input  logic [tbft_pkg::TOK_W:0]      i_a,
    input  logic [tbft_pkg::TOK_W:0]      i_b,
    output tbft_pkg::t_alu_res            o_res
);
    import tbft_pkg::*;

    logic [TOK_W+1:0] wide;

    always_comb begin
        case (i_op)
            ALU_ADD: wide = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: wide = {1'b0, i_a} - {1'b0, i_b};
            default: wide = '0;
        endcase
    end

    // top bit of a subtract is set exactly when a < b
    assign o_res.borrow = wide[TOK_W+1];
    assign o_res.value  = wide[TOK_W:0];

endmodule

>>> src/tbft_queue.sv
// Wait queue: circular buffer of tag and token count with a registered head read.
module tbft_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbft_pkg::t_q_ctrl             i_ctrl,
    input  logic [tbft_pkg::TAG_W-1:0]    i_wr_tag,
    input  logic [tbft_pkg::TOK_W-1:0]    i_wr_amt,
    output logic [tbft_pkg::TAG_W-1:0]    o_rd_tag,
    output logic [tbft_pkg::TOK_W-1:0]    o_rd_amt,
    output tbft_pkg::t_q_status           o_status
);
    import tbft_pkg::*;

    logic [TAG_W+TOK_W-1:0] mem [QUEUE_DEPTH];
    logic [TAG_W+TOK_W-1:0] r_rd;
    logic [QPTR_W-1:0]      r_head, n_head;
    logic [QPTR_W-1:0]      r_tail, n_tail;
    logic [QCNT_W-1:0]      r_count, n_count;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_tail = next_ptr(r_tail);
        end
        if (i_ctrl.pop) begin
            n_head = next_ptr(r_head);
        end
        case ({i_ctrl.push, i_ctrl.pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // head data is registered, so it follows the head pointer in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_tail] <= {i_wr_tag, i_wr_amt};
        end
        r_rd <= mem[r_head];
    end

    assign o_rd_tag       = r_rd[TAG_W+TOK_W-1:TOK_W];
    assign o_rd_amt       = r_rd[TOK_W-1:0];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

>>> src/token_bucket_fifo_throttle_unit.sv
// Request: accepted in S_IDLE, then in S_REQ its result is registered or it is queued; no new
// item is taken until the machine is back in S_IDLE. Tick: refill in S_ADD and cap in S_CAP,
// then S_FETCH and S_CHECK per queued grant through the shared subtract unit and the registered
// queue read, plus one final check; at zero rate the cap step is skipped.
// The machine stalls while the output register is full and not taken.
// Reset is synchronous and active low: bucket, state, config, count and valid registers and
// pointers clear at once; data registers and queue storage are not cleared and need no sweep.
module token_bucket_fifo_throttle_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [tbft_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [tbft_pkg::TOK_W-1:0]         i_cfg_wdata,
    // request stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [39:0]                        i_s_axis_tdata,  // req_tag[7:0], tokens_wanted[39:8]
    input  logic                               i_s_axis_tuser,  // op
    // grant stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [39:0]                        o_m_axis_tdata,  // grant_tag[7:0], grant_amount[39:8]
    output logic                               o_m_axis_tuser,  // from_queue
    output logic                               o_m_axis_tlast   // last_grant
);
    import tbft_pkg::*;

    t_state             r_state, n_state;
    logic [TOK_W-1:0]   r_token_rate, n_token_rate;
    logic [TOK_W-1:0]   r_max_tokens, n_max_tokens;
    logic [TOK_W-1:0]   r_level, n_level;
    logic [TOK_W:0]     r_sum, n_sum;
    logic               r_op, n_op;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [TOK_W-1:0]   r_want, n_want;
    logic [REL_W-1:0]   r_rel_cnt, n_rel_cnt;
    logic               r_held_vld, n_held_vld;
    logic [TAG_W-1:0]   r_held_tag, n_held_tag;
    logic [TOK_W-1:0]   r_held_amt, n_held_amt;
    logic               r_out_vld, n_out_vld;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [TOK_W-1:0]   r_out_amt, n_out_amt;
    logic               r_out_fq, n_out_fq;
    logic               r_out_last, n_out_last;

    t_alu_op            alu_op;
    logic [TOK_W:0]     alu_a, alu_b;
    t_alu_res           alu_res;
    t_q_ctrl            q_ctrl;
    t_q_status          q_st;
    logic [TAG_W-1:0]   q_rd_tag;
    logic [TOK_W-1:0]   q_rd_amt;

    logic               s_fire;
    logic               out_free;
    logic               rate_zero;
    logic               req_charge;
    logic               req_emit;
    logic               rel_ok;
    logic               held_stall;

    tbft_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    tbft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (q_ctrl),
        .i_wr_tag (r_tag),
        .i_wr_amt (r_want),
        .o_rd_tag (q_rd_tag),
        .o_rd_amt (q_rd_amt),
        .o_status (q_st)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign rate_zero       = (r_token_rate == '0);

    // operand select for the shared unit
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, r_level};
        alu_b  = {1'b0, r_want};
        case (r_state)
            S_ADD: begin
                alu_op = ALU_ADD;
                alu_b  = {1'b0, r_token_rate};
            end
            S_CAP: begin
                alu_a = {1'b0, r_max_tokens};
                alu_b = r_sum;
            end
            S_CHECK: begin
                alu_b = {1'b0, q_rd_amt};
            end
            default: begin
                alu_b = {1'b0, r_want};
            end
        endcase
    end

    assign req_charge = !rate_zero && !alu_res.borrow;
    assign req_emit   = rate_zero || !alu_res.borrow || q_st.full;
    assign rel_ok     = !q_st.empty && (r_rel_cnt < REL_W'(MAX_RESULTS))
                        && (rate_zero || !alu_res.borrow);
    assign held_stall = r_held_vld && !out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = (i_s_axis_tuser == OP_TICK) ? S_ADD : S_REQ;
                end
            end
            S_REQ: begin
                if (!req_emit || out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                n_state = rate_zero ? S_FETCH : S_CAP;
            end
            S_CAP: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!held_stall) begin
                    n_state = rel_ok ? S_FETCH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_token_rate = r_token_rate;
        n_max_tokens = r_max_tokens;
        n_level      = r_level;
        n_sum        = r_sum;
        n_op         = r_op;
        n_tag        = r_tag;
        n_want       = r_want;
        n_rel_cnt    = r_rel_cnt;
        n_held_vld   = r_held_vld;
        n_held_tag   = r_held_tag;
        n_held_amt   = r_held_amt;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_tag    = r_out_tag;
        n_out_amt    = r_out_amt;
        n_out_fq     = r_out_fq;
        n_out_last   = r_out_last;
        q_ctrl       = '0;

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_op       = i_s_axis_tuser;
                    n_tag      = i_s_axis_tdata[TAG_W-1:0];
                    n_want     = i_s_axis_tdata[TAG_W+TOK_W-1:TAG_W];
                    n_rel_cnt  = '0;
                    n_held_vld = 1'b0;
                end
            end
            S_REQ: begin
                if (req_emit) begin
                    if (out_free) begin
                        n_out_vld  = 1'b1;
                        n_out_tag  = r_tag;
                        n_out_amt  = req_charge ? r_want : '0;
                        n_out_fq   = 1'b0;
                        n_out_last = 1'b1;
                        if (req_charge) begin
                            n_level = alu_res.value[TOK_W-1:0];
                        end
                    end
                end else begin
                    q_ctrl.push = 1'b1;
                end
            end
            S_ADD: begin
                n_sum = alu_res.value;
            end
            S_CAP: begin
                // max - sum borrows when the refill overshoots the cap
                n_level = alu_res.borrow ? r_max_tokens : r_sum[TOK_W-1:0];
            end
            S_CHECK: begin
                if (!held_stall) begin
                    if (r_held_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_tag  = r_held_tag;
                        n_out_amt  = r_held_amt;
                        n_out_fq   = 1'b1;
                        n_out_last = !rel_ok;
                    end
                    if (rel_ok) begin
                        // keep one grant back until we know whether another follows
                        n_held_vld  = 1'b1;
                        n_held_tag  = q_rd_tag;
                        n_held_amt  = rate_zero ? '0 : q_rd_amt;
                        q_ctrl.pop  = 1'b1;
                        n_rel_cnt   = r_rel_cnt + REL_W'(1);
                        if (!rate_zero) begin
                            n_level = alu_res.value[TOK_W-1:0];
                        end
                    end else begin
                        n_held_vld = 1'b0;
                    end
                end
            end
            default: begin
                n_sum = r_sum;
            end
        endcase

        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_TOKEN_RATE: begin
                    n_token_rate = i_cfg_wdata;
                    n_level      = '0;
                end
                CFG_MAX_TOKENS: begin
                    n_max_tokens = i_cfg_wdata;
                    n_level      = '0;
                end
                default: begin
                    n_level = n_level;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_token_rate <= '0;
            r_max_tokens <= '0;
            r_level      <= '0;
            r_rel_cnt    <= '0;
            r_held_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_token_rate <= n_token_rate;
            r_max_tokens <= n_max_tokens;
            r_level      <= n_level;
            r_rel_cnt    <= n_rel_cnt;
            r_held_vld   <= n_held_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_op       <= n_op;
        r_tag      <= n_tag;
        r_want     <= n_want;
        r_held_tag <= n_held_tag;
        r_held_amt <= n_held_amt;
        r_out_tag  <= n_out_tag;
        r_out_amt  <= n_out_amt;
        r_out_fq   <= n_out_fq;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_amt, r_out_tag};
    assign o_m_axis_tuser  = r_out_fq;
    assign o_m_axis_tlast  = r_out_last;

    // a held queue grant must be flushed before the next request is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_held_vld)
        else $error("held grant left behind at idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel_cnt <= REL_W'(MAX_RESULTS))
        else $error("too many releases on one tick");

    // an immediate grant is always the only result of its request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("immediate grant not marked last");

    // a tick never reaches the request path
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REQ) |-> (r_op == OP_REQUEST))
        else $error("tick routed to request path");

endmodule
